>>> src/tfct_pkg.sv
package tfct_pkg;

  localparam int PALETTE_ENTRIES_DEF = 65536;
  localparam int MAX_DIM_DEF         = 1024;

  localparam int CMD_W    = 1;
  localparam int COORD_W  = 10;
  localparam int TEXEL_W  = 32;
  localparam int PIDX_W   = 16;
  localparam int COLOR_W  = 32;
  localparam int ADDR_W   = 21;
  localparam int WORD_W   = 16;
  localparam int FMT_W    = 3;
  localparam int DIM_W    = 11;
  localparam int CFG_IDX_W = 2;

  localparam int S_DATA_W = 104;  // 100 bits of fields, padded to bytes
  localparam int M_DATA_W = 56;   // 53 bits of fields, padded to bytes

  // command codes
  localparam logic [CMD_W-1:0] CMD_CONVERT   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PAL_WRITE = 1'b1;

  // texel formats
  localparam logic [FMT_W-1:0] FMT_ARGB32    = 3'd0;
  localparam logic [FMT_W-1:0] FMT_PAL_OPQ   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_PAL_ALPHA = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGB5551   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_YCBCR     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_HEIGHT = 2'd2;

  // Stage-1 contents handed to the color converter
  typedef struct packed {
    logic [FMT_W-1:0]   fmt;
    logic               in_range;
    logic [TEXEL_W-1:0] texel;
    logic [COLOR_W-1:0] pal;
    logic [16:0]        y298;
    logic [16:0]        cr409;
    logic [14:0]        cb100;
    logic [15:0]        cr208;
    logic [17:0]        cb516;
  } tfct_stage_t;

endpackage

>>> src/tfct_color.sv
module tfct_color (
  input  tfct_pkg::tfct_stage_t            stage,
  output logic [tfct_pkg::WORD_W-1:0]      word_first,
  output logic [tfct_pkg::WORD_W-1:0]      word_second
);
  import tfct_pkg::*;

  logic signed [19:0] common, rv, gv, bv;
  logic [7:0] r8, g8, b8;
  logic [7:0] pa, pr, pg, pb;
  logic [15:0] c16;

  function automatic logic [7:0] sat8(input logic signed [19:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 20'sd65535) begin
      res = 8'd255;
    end else begin
      res = v[15:8];
    end
    return res;
  endfunction

  always_comb begin
    common = signed'(20'(stage.y298)) - 20'sd56992;
    rv = common + signed'(20'(stage.cr409));
    gv = common - signed'(20'(stage.cb100)) - signed'(20'(stage.cr208)) + 20'sd91776;
    bv = common + signed'(20'(stage.cb516)) - 20'sd13696;
    r8 = sat8(rv);
    g8 = sat8(gv);
    b8 = sat8(bv);

    pa  = stage.pal[31:24];
    pr  = stage.pal[23:16];
    pg  = stage.pal[15:8];
    pb  = stage.pal[7:0];
    c16 = stage.texel[15:0];

    word_first  = '0;
    word_second = '0;
    if (stage.in_range) begin
      case (stage.fmt)
        FMT_ARGB32: begin
          word_first  = stage.texel[31:16];
          word_second = stage.texel[15:0];
        end
        FMT_PAL_OPQ: begin
          word_first = {1'b1, pr[7:3], pg[7:3], pb[7:3]};
        end
        FMT_PAL_ALPHA: begin
          word_first = {1'b0, pa[7:5], pr[7:4], pg[7:4], pb[7:4]};
        end
        FMT_RGB5551: begin
          if (c16[0]) begin
            word_first = {1'b1, c16[15:11], c16[10:6], c16[5:1]};
          end else begin
            word_first = {4'b0, c16[15:12], c16[10:7], c16[5:2]};
          end
        end
        FMT_YCBCR: begin
          word_first  = {8'hFF, r8};
          word_second = {g8, b8};
        end
        default: begin
          word_first  = '0;
          word_second = '0;
        end
      endcase
    end
  end

endmodule

>>> src/texel_format_convert_and_tile.sv
// Texel format converter and 4x4 tiler. Each input transaction is either a
// palette write (tuser = 1) or a texel conversion (tuser = 0); conversions give
// one output transaction with the tiled 16-bit word address and the converted
// word(s), palette writes and unknown formats give none. One transaction is
// taken every cycle while not stalled; a conversion passes the stage-1 and
// output registers. The palette lives in a single-port-write, registered-read
// memory of PALETTE_ENTRIES words, read in the accept cycle. PALETTE_ENTRIES
// must be a power of two (the texel's low bits index it). The palette holds
// no reset value; looking up an entry never written gives an unspecified color.
module texel_format_convert_and_tile #(
  parameter int PALETTE_ENTRIES = tfct_pkg::PALETTE_ENTRIES_DEF,
  parameter int MAX_DIM         = tfct_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tex_x[9:0], tex_y[19:10], texel_value[51:20], pal_index[67:52],
  // pal_color[99:68], zero pad
  input  logic [tfct_pkg::S_DATA_W-1:0]       s_tdata,
  // cmd
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // word_addr[20:0], word_first[36:21], word_second[52:37], zero pad
  output logic [tfct_pkg::M_DATA_W-1:0]       m_tdata,
  // second_valid
  output logic                                m_tuser,
  input  logic                                cfg_we,
  input  logic [tfct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfct_pkg::DIM_W-1:0]          cfg_wdata
);
  import tfct_pkg::*;

  localparam int AW   = $clog2(PALETTE_ENTRIES);
  localparam int MDW  = $clog2(MAX_DIM + 1);
  localparam int SW   = (MDW > DIM_W) ? MDW : DIM_W;
  localparam int TPRW = SW - 1;
  localparam int PRW  = (COORD_W - 2) + TPRW;

  // configuration
  logic [FMT_W-1:0] texel_format;
  logic [DIM_W-1:0] raw_width, raw_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format <= FMT_ARGB32;
      raw_width    <= DIM_W'(1);
      raw_height   <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT:     texel_format <= cfg_wdata[FMT_W-1:0];
        REG_RAW_WIDTH:  raw_width    <= cfg_wdata;
        REG_RAW_HEIGHT: raw_height   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input fields
  logic [COORD_W-1:0] in_x, in_y;
  logic [TEXEL_W-1:0] in_texel;
  logic [PIDX_W-1:0]  in_pidx;
  logic [COLOR_W-1:0] in_pcol;

  assign in_x     = s_tdata[9:0];
  assign in_y     = s_tdata[19:10];
  assign in_texel = s_tdata[51:20];
  assign in_pidx  = s_tdata[67:52];
  assign in_pcol  = s_tdata[99:68];

  logic s_acc, out_take, s1_valid;
  assign out_take = !m_tvalid || m_tready;
  assign s_tready = out_take || !s1_valid;
  assign s_acc    = s_tvalid && s_tready;

  // saturated size and tiles per row
  logic [SW-1:0]   rw, rh, rw_ext, rh_ext;
  logic [SW:0]     rw_pad;
  logic [TPRW-1:0] tiles_per_row;

  always_comb begin
    rw_ext = SW'(raw_width);
    rh_ext = SW'(raw_height);
    rw = (rw_ext > SW'(MAX_DIM)) ? SW'(MAX_DIM) : rw_ext;
    rh = (rh_ext > SW'(MAX_DIM)) ? SW'(MAX_DIM) : rh_ext;
    rw_pad = {1'b0, rw} + (SW+1)'(3);
    tiles_per_row = rw_pad[SW:2];
  end

  // palette memory
  logic [COLOR_W-1:0] pal_mem [PALETTE_ENTRIES];
  logic [COLOR_W-1:0] pal_rdata;
  logic pal_wr, is_convert;

  assign is_convert = (s_tuser == CMD_CONVERT);
  assign pal_wr = s_acc && (s_tuser == CMD_PAL_WRITE)
                  && ({1'b0, in_pidx} < 17'(PALETTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem[in_pidx[AW-1:0]] <= in_pcol;
    end
    if (s_acc && is_convert) begin
      pal_rdata <= pal_mem[in_texel[AW-1:0]];
    end
  end

  // stage 1: multiplies
  logic [COORD_W-1:0] s1_x, s1_y;
  logic [PRW-1:0]     s1_row_prod;
  logic               s1_inside, s1_wide;
  logic [FMT_W-1:0]   s1_fmt;
  logic [TEXEL_W-1:0] s1_texel;
  logic [16:0] s1_y298, s1_cr409;
  logic [14:0] s1_cb100;
  logic [15:0] s1_cr208;
  logic [17:0] s1_cb516;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_acc && is_convert && (texel_format <= FMT_YCBCR);
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && is_convert) begin
      s1_x        <= in_x;
      s1_y        <= in_y;
      s1_row_prod <= PRW'(in_y[COORD_W-1:2]) * PRW'(tiles_per_row);
      s1_inside   <= (SW'(in_x) < rw) && (SW'(in_y) < rh);
      s1_wide     <= (texel_format == FMT_ARGB32) || (texel_format == FMT_YCBCR);
      s1_fmt      <= texel_format;
      s1_texel    <= in_texel;
      s1_y298     <= 17'(in_texel[7:0]) * 17'd298;
      s1_cr409    <= 17'(in_texel[23:16]) * 17'd409;
      s1_cb100    <= 15'(in_texel[15:8]) * 15'd100;
      s1_cr208    <= 16'(in_texel[23:16]) * 16'd208;
      s1_cb516    <= 18'(in_texel[15:8]) * 18'd516;
    end
  end

  // stage 2: address sum and color conversion
  tfct_stage_t stage;
  logic [WORD_W-1:0] conv_first, conv_second;
  logic [ADDR_W-1:0] tile, addr_next;

  always_comb begin
    stage.fmt      = s1_fmt;
    stage.in_range = s1_inside;
    stage.texel    = s1_texel;
    stage.pal      = pal_rdata;
    stage.y298     = s1_y298;
    stage.cr409    = s1_cr409;
    stage.cb100    = s1_cb100;
    stage.cr208    = s1_cr208;
    stage.cb516    = s1_cb516;

    tile = ADDR_W'(s1_row_prod) + ADDR_W'(s1_x[COORD_W-1:2]);
    addr_next = (s1_wide ? {tile[ADDR_W-6:0], 5'b0} : {tile[ADDR_W-5:0], 4'b0})
              | ADDR_W'({s1_y[1:0], s1_x[1:0]});
  end

  tfct_color u_color (
    .stage       (stage),
    .word_first  (conv_first),
    .word_second (conv_second)
  );

  logic [ADDR_W-1:0] out_addr;
  logic [WORD_W-1:0] out_first, out_second;
  logic              out_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_take) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid) begin
      out_addr   <= addr_next;
      out_first  <= conv_first;
      out_second <= conv_second;
      out_wide   <= s1_wide;
    end
  end

  assign m_tdata = {3'b0, out_second, out_first, out_addr};
  assign m_tuser = out_wide;

  // stall only comes from a full pipe
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid))
    else $error("input stalled with room in the pipe");

  // palette writes never produce a result
  assert property (@(posedge clk) disable iff (rst)
    (s_acc && (s_tuser == CMD_PAL_WRITE)) |=> !s1_valid)
    else $error("palette write entered the result pipe");

  // narrow formats leave the second word clear
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (out_second == '0))
    else $error("second word set for a 16-bit format");

  // a result held in stage 1 is not lost while the output stalls
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_take) |=> s1_valid)
    else $error("stage 1 result dropped under stall");

endmodule
